>>> hdl/lce_pkg.sv
// Shared constants for the min line envelope tree.
`timescale 1ns / 1ps
package lce_pkg;

  // Default geometry
  localparam int unsigned XBitsDefault = 20;
  localparam int unsigned NodesDefault = 4096;

  // Field widths
  localparam int unsigned SlopeW = 32;
  localparam int unsigned InterW = 48;
  localparam int unsigned QueryW = 20;
  localparam int unsigned ValW   = 64;

  // Opcodes
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpQuery  = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

endpackage

>>> hdl/lce_eval.sv
// Shared line evaluator: k*x + b in 64-bit wrapping arithmetic, two stages.
`timescale 1ns / 1ps
module lce_eval import lce_pkg::*; #(
  parameter int unsigned XBits = XBitsDefault
) (
  input  logic                     clk_i,
  input  logic signed [SlopeW-1:0] k_i,
  input  logic signed [InterW-1:0] b_i,
  input  logic [XBits-1:0]         x_i,
  output logic [ValW-1:0]          val_o
);

  localparam int unsigned PW = XBits + SlopeW + 1;

  logic signed [PW-1:0]     prod;
  logic [ValW-1:0]          prod64;
  logic [ValW-1:0]          prod_q;
  logic signed [InterW-1:0] b_q;
  logic [ValW-1:0]          val_q;

  // x is unsigned, so give it a zero sign bit
  assign prod = k_i * $signed({1'b0, x_i});

  if (PW >= ValW) begin : g_trunc
    assign prod64 = prod[ValW-1:0];
  end else begin : g_sext
    assign prod64 = {{(ValW-PW){prod[PW-1]}}, prod};
  end

  // Stage 1 multiply, stage 2 add intercept
  always_ff @(posedge clk_i) begin
    prod_q <= prod64;
    b_q    <= b_i;
    val_q  <= prod_q + {{(ValW-InterW){b_q[InterW-1]}}, b_q};
  end

  assign val_o = val_q;

endmodule

>>> hdl/lce_node_store.sv
// Node pool storage: line and child pointer memories with registered reads.
`timescale 1ns / 1ps
module lce_node_store import lce_pkg::*; #(
  parameter int unsigned Nodes = NodesDefault,
  localparam int unsigned NW   = $clog2(Nodes)
) (
  input  logic              clk_i,
  input  logic [NW-1:0]     rd_addr_i,
  output logic [SlopeW-1:0] rd_k_o,
  output logic [InterW-1:0] rd_b_o,
  output logic [NW-1:0]     rd_left_o,
  output logic [NW-1:0]     rd_right_o,
  input  logic              line_we_i,
  input  logic [NW-1:0]     line_addr_i,
  input  logic [SlopeW-1:0] line_k_i,
  input  logic [InterW-1:0] line_b_i,
  input  logic              left_we_i,
  input  logic              right_we_i,
  input  logic [NW-1:0]     child_addr_i,
  input  logic [NW-1:0]     child_data_i
);

  logic [SlopeW+InterW-1:0] line_mem [Nodes];
  logic [NW-1:0]            left_mem [Nodes];
  logic [NW-1:0]            right_mem[Nodes];
  logic [SlopeW+InterW-1:0] line_rd_q;
  logic [NW-1:0]            left_rd_q;
  logic [NW-1:0]            right_rd_q;

  // Writes
  always_ff @(posedge clk_i) begin
    if (line_we_i) begin
      line_mem[line_addr_i] <= {line_k_i, line_b_i};
    end
    if (left_we_i) begin
      left_mem[child_addr_i] <= child_data_i;
    end
    if (right_we_i) begin
      right_mem[child_addr_i] <= child_data_i;
    end
  end

  // Reads
  always_ff @(posedge clk_i) begin
    line_rd_q  <= line_mem[rd_addr_i];
    left_rd_q  <= left_mem[rd_addr_i];
    right_rd_q <= right_mem[rd_addr_i];
  end

  assign rd_k_o     = line_rd_q[SlopeW+InterW-1:InterW];
  assign rd_b_o     = line_rd_q[InterW-1:0];
  assign rd_left_o  = left_rd_q;
  assign rd_right_o = right_rd_q;

endmodule

>>> hdl/line_envelope_min_tree.sv
// Top level: min line envelope tree, sequencer around a shared evaluator.
// Insert: each tree level runs fetch, load and up to three compares (mid, then lo, then hi),
//   descending at most until the interval is a single point; the single multiply-add evaluator
//   is used twice per compare. Query: fetch, load and one evaluation per level.
// One transaction at a time; the next is taken while a result waits on the output.
// Reset (async, active low) empties the tree; node memories are not cleared.
`timescale 1ns / 1ps
module line_envelope_min_tree import lce_pkg::*; #(
  parameter int unsigned X_BITS = XBitsDefault,
  parameter int unsigned NODES  = NodesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [SlopeW-1:0] line_slope_i,
  input  logic signed [InterW-1:0] line_intercept_i,
  input  logic [QueryW-1:0]        query_x_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValW-1:0]   min_value_o,
  output logic                     no_line_o,
  output logic                     status_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam logic [NW:0] NodesW = (NW+1)'(NODES);
  localparam logic [NW-1:0] LastNode = NW'(NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_LOAD, S_EVAL, S_LINK, S_DONE
  } state_e;

  typedef enum logic [1:0] {ST_MID, ST_LO, ST_HI} step_e;

  state_e            state_q;
  step_e             step_q;
  logic [1:0]        ph_q;
  logic              is_query_q;
  logic [SlopeW-1:0] car_k_q, nod_k_q;
  logic [InterW-1:0] car_b_q, nod_b_q;
  logic [X_BITS-1:0] lo_q, hi_q, qx_q;
  logic [NW-1:0]     p_q, parent_q, root_q, used_q;
  logic              side_q, at_root_q, found_q;
  logic [ValW-1:0]   va_q, best_q;
  logic [ValW-1:0]   res_min_q;
  logic              res_nol_q, res_st_q;
  logic              out_valid_q;
  logic [ValW-1:0]   out_min_q;
  logic              out_nol_q, out_st_q;

  logic [X_BITS-1:0] mid, qx_in, ev_x;
  logic [NW-1:0]     p_fetch, rd_addr, n_new, rd_left, rd_right;
  logic              p_ok, full, lt_ins, lt_qry;
  logic [SlopeW-1:0] ev_k, rd_k;
  logic [InterW-1:0] ev_b, rd_b;
  logic [ValW-1:0]   ev_val, new_best;
  logic              line_we, left_we, right_we;
  logic [NW-1:0]     line_addr, child_addr, child_data;

  // Query point reduced to the domain
  if (X_BITS <= QueryW) begin : g_qx_cut
    assign qx_in = query_x_i[X_BITS-1:0];
  end else begin : g_qx_ext
    assign qx_in = {{(X_BITS-QueryW){1'b0}}, query_x_i};
  end

  // Node geometry and pointer selection
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign p_fetch = at_root_q ? root_q : (side_q ? rd_right : rd_left);
  assign p_ok    = (p_fetch != '0) && ({1'b0, p_fetch} < NodesW);
  assign full    = (used_q == LastNode);
  assign n_new   = used_q + 1'b1;
  // read the next node while fetching, otherwise keep the current node on the read port
  assign rd_addr = (state_q == S_FETCH) ? p_fetch : p_q;

  // Evaluator operands: insert evaluates carried line then node line
  always_comb begin
    if (!is_query_q && ph_q == 2'd0) begin
      ev_k = car_k_q;
      ev_b = car_b_q;
    end else begin
      ev_k = nod_k_q;
      ev_b = nod_b_q;
    end
    if (is_query_q) begin
      ev_x = qx_q;
    end else begin
      unique case (step_q)
        ST_MID:  ev_x = mid;
        ST_LO:   ev_x = lo_q;
        default: ev_x = hi_q;
      endcase
    end
  end

  assign lt_ins   = $signed(va_q) < $signed(ev_val);
  assign lt_qry   = $signed(ev_val) < $signed(best_q);
  assign new_best = (!found_q || lt_qry) ? ev_val : best_q;

  // Memory write control
  always_comb begin
    line_we    = 1'b0;
    line_addr  = p_q;
    left_we    = 1'b0;
    right_we   = 1'b0;
    child_addr = parent_q;
    child_data = p_q;
    if (state_q == S_FETCH && !is_query_q && !p_ok && !full) begin
      // allocate a fresh node holding the carried line
      line_we    = 1'b1;
      line_addr  = n_new;
      left_we    = 1'b1;
      right_we   = 1'b1;
      child_addr = n_new;
      child_data = '0;
    end else if (state_q == S_EVAL && !is_query_q && ph_q == 2'd3 &&
                 step_q == ST_MID && lt_ins) begin
      line_we = 1'b1;
    end else if (state_q == S_LINK) begin
      left_we  = !side_q;
      right_we = side_q;
    end
  end

  lce_eval #(
    .XBits(X_BITS)
  ) u_eval (
    .clk_i(clk_i),
    .k_i  (ev_k),
    .b_i  (ev_b),
    .x_i  (ev_x),
    .val_o(ev_val)
  );

  lce_node_store #(
    .Nodes(NODES)
  ) u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_k_o      (rd_k),
    .rd_b_o      (rd_b),
    .rd_left_o   (rd_left),
    .rd_right_o  (rd_right),
    .line_we_i   (line_we),
    .line_addr_i (line_addr),
    .line_k_i    (car_k_q),
    .line_b_i    (car_b_q),
    .left_we_i   (left_we),
    .right_we_i  (right_we),
    .child_addr_i(child_addr),
    .child_data_i(child_data)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_MID;
      ph_q        <= '0;
      is_query_q  <= 1'b0;
      car_k_q     <= '0;
      car_b_q     <= '0;
      nod_k_q     <= '0;
      nod_b_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      qx_q        <= '0;
      p_q         <= '0;
      parent_q    <= '0;
      root_q      <= '0;
      used_q      <= '0;
      side_q      <= 1'b0;
      at_root_q   <= 1'b1;
      found_q     <= 1'b0;
      va_q        <= '0;
      best_q      <= '0;
      res_min_q   <= '0;
      res_nol_q   <= 1'b0;
      res_st_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_min_q   <= '0;
      out_nol_q   <= 1'b0;
      out_st_q    <= 1'b0;
    end else begin
      // output drains here unless a new result is loaded below
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_min_q  <= '0;
            res_nol_q  <= 1'b0;
            res_st_q   <= 1'b0;
            lo_q       <= '0;
            hi_q       <= '1;
            at_root_q  <= 1'b1;
            found_q    <= 1'b0;
            car_k_q    <= line_slope_i;
            car_b_q    <= line_intercept_i;
            qx_q       <= qx_in;
            unique case (opcode_i)
              OpInsert: begin
                is_query_q <= 1'b0;
                state_q    <= S_FETCH;
              end
              OpQuery: begin
                is_query_q <= 1'b1;
                state_q    <= S_FETCH;
              end
              OpClear: begin
                root_q  <= '0;
                used_q  <= '0;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_FETCH: begin
          if (p_ok) begin
            p_q     <= p_fetch;
            state_q <= S_LOAD;
          end else if (is_query_q) begin
            res_min_q <= found_q ? best_q : '0;
            res_nol_q <= !found_q;
            state_q   <= S_DONE;
          end else if (full) begin
            res_st_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            used_q <= n_new;
            p_q    <= n_new;
            if (at_root_q) begin
              root_q  <= n_new;
              state_q <= S_DONE;
            end else begin
              state_q <= S_LINK;
            end
          end
        end
        S_LOAD: begin
          nod_k_q <= rd_k;
          nod_b_q <= rd_b;
          ph_q    <= '0;
          step_q  <= ST_MID;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          // phase wraps from 3 back to 0 on its own
          ph_q <= ph_q + 2'd1;
          if (is_query_q) begin
            if (ph_q == 2'd2) begin
              best_q  <= new_best;
              found_q <= 1'b1;
              if (lo_q == hi_q) begin
                res_min_q <= new_best;
                state_q   <= S_DONE;
              end else begin
                if (qx_q <= mid) begin
                  hi_q   <= mid;
                  side_q <= 1'b0;
                end else begin
                  lo_q   <= mid + 1'b1;
                  side_q <= 1'b1;
                end
                parent_q  <= p_q;
                at_root_q <= 1'b0;
                state_q   <= S_FETCH;
              end
            end
          end else begin
            if (ph_q == 2'd2) begin
              va_q <= ev_val;
            end else if (ph_q == 2'd3) begin
              unique case (step_q)
                ST_MID: begin
                  // keep the line lower at mid, carry the other down
                  if (lt_ins) begin
                    car_k_q <= nod_k_q;
                    car_b_q <= nod_b_q;
                    nod_k_q <= car_k_q;
                    nod_b_q <= car_b_q;
                  end
                  if (lo_q == hi_q) begin
                    state_q <= S_DONE;
                  end else begin
                    step_q <= ST_LO;
                  end
                end
                ST_LO: begin
                  if (lt_ins) begin
                    hi_q      <= mid;
                    side_q    <= 1'b0;
                    parent_q  <= p_q;
                    at_root_q <= 1'b0;
                    state_q   <= S_FETCH;
                  end else begin
                    step_q <= ST_HI;
                  end
                end
                default: begin
                  if (lt_ins) begin
                    lo_q      <= mid + 1'b1;
                    side_q    <= 1'b1;
                    parent_q  <= p_q;
                    at_root_q <= 1'b0;
                    state_q   <= S_FETCH;
                  end else begin
                    state_q <= S_DONE;
                  end
                end
              endcase
            end
          end
        end
        S_LINK: begin
          state_q <= S_DONE;
        end
        default: begin
          // hand the result to the output register once it is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_min_q   <= res_min_q;
            out_nol_q   <= res_nol_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign min_value_o = out_min_q;
  assign no_line_o   = out_nol_q;
  assign status_o    = out_st_q;

endmodule
